// ===== rtl/core/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// psu_pkg
// Types and constants shared by the scanline unfilter modules.
// ----------------------------------------------------------------------------
package psu_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_BITS   = 2'd2;

	localparam logic [2:0] FILT_NONE  = 3'd0;
	localparam logic [2:0] FILT_SUB   = 3'd1;
	localparam logic [2:0] FILT_UP    = 3'd2;
	localparam logic [2:0] FILT_AVG   = 3'd3;
	localparam logic [2:0] FILT_PAETH = 3'd4;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	typedef enum logic [1:0] {
		ITEM_TYPE,
		ITEM_DATA,
		ITEM_ERR
	} item_kind_t;

	typedef struct packed {
		item_kind_t  kind;
		logic [2:0]  filter;
		logic        row0;
		logic        row_end;
		logic        image_end;
		logic [2:0]  lag_sel;
		logic [3:0]  eb;
		logic [3:0]  nsamp;
		logic [15:0] count;
		logic [7:0]  data;
	} front_item_t;

	typedef struct packed {
		logic [7:0] value;
		logic       status;
		logic [3:0] eb;
		logic [3:0] nsamp;
		logic       row_end;
		logic       image_end;
	} entry_t;

endpackage

// ===== rtl/core/psu_front.sv =====
// ----------------------------------------------------------------------------
// psu_front
// Accepts stream bytes, holds configuration and row position, classifies each
// item and issues the prior-row read.
// ----------------------------------------------------------------------------
module psu_front #(
	parameter int MAX_ROW_BYTES   = 32768,
	parameter int MAX_PIXEL_BYTES = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [psu_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [psu_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             push,
	input  logic                             full,
	input  logic [7:0]                       filtered_byte,
	output psu_pkg::front_item_t             item_s1,
	output logic                             valid_s1,
	output logic                             rd_en,
	output logic [15:0]                      rd_addr
);
	import psu_pkg::*;

	logic [12:0] width_q;
	logic [15:0] height_q;
	logic [6:0]  pix_bits_q;

	logic        awaiting_q;
	logic        err_stop_q;
	logic [2:0]  filter_q;
	logic [15:0] count_q;
	logic [15:0] row_q;

	logic        accept;
	logic [12:0] w_eff;
	logic [15:0] h_eff;
	logic [3:0]  eb;
	logic [3:0]  per;
	logic [4:0]  bpp_raw;
	logic [4:0]  bpp;
	logic [16:0] rb_raw;
	logic [16:0] rb;
	logic        row_end;
	logic        image_end;
	logic [19:0] first;
	logic [19:0] rem;
	logic [3:0]  nsamp;

	assign accept = push && !full;

	always_comb begin
		w_eff = width_q;
		if (width_q == 13'd0) begin
			w_eff = 13'd1;
		end else if (width_q > 13'd4096) begin
			w_eff = 13'd4096;
		end
		h_eff = (height_q == 16'd0) ? 16'd1 : height_q;

		if (pix_bits_q <= 7'd1) begin
			eb = 4'd1;
		end else if (pix_bits_q == 7'd2) begin
			eb = 4'd2;
		end else if (pix_bits_q <= 7'd4) begin
			eb = 4'd4;
		end else begin
			eb = 4'd8;
		end

		bpp_raw = 5'((8'(pix_bits_q) + 8'd7) >> 3);
		bpp = bpp_raw;
		if (int'(bpp_raw) > MAX_PIXEL_BYTES) begin
			bpp = 5'(MAX_PIXEL_BYTES);
		end
		if (eb != 4'd8) begin
			bpp = 5'd1;
		end

		if (eb != 4'd8) begin
			rb_raw = (17'(w_eff) * 17'(eb) + 17'd7) >> 3;
		end else begin
			rb_raw = 17'(w_eff) * 17'(bpp);
		end
		rb = rb_raw;
		if (int'(rb_raw) > MAX_ROW_BYTES) begin
			rb = 17'(MAX_ROW_BYTES);
		end

		row_end   = (17'(count_q) + 17'd1) >= rb;
		image_end = row_end && ((17'(row_q) + 17'd1) >= 17'(h_eff));

		case (eb)
			4'd1: begin
				per   = 4'd8;
				first = 20'(count_q) << 3;
			end
			4'd2: begin
				per   = 4'd4;
				first = 20'(count_q) << 2;
			end
			4'd4: begin
				per   = 4'd2;
				first = 20'(count_q) << 1;
			end
			default: begin
				per   = 4'd1;
				first = 20'(count_q);
			end
		endcase
		rem = (20'(w_eff) > first) ? (20'(w_eff) - first) : 20'd0;
		if (eb == 4'd8) begin
			nsamp = 4'd1;
		end else if (rem < 20'(per)) begin
			nsamp = rem[3:0];
		end else begin
			nsamp = per;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= 13'd1;
			height_q   <= 16'd1;
			pix_bits_q <= 7'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q    <= cfg_data[12:0];
				REG_IMAGE_HEIGHT: height_q   <= cfg_data;
				REG_PIXEL_BITS:   pix_bits_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b1;
			err_stop_q <= 1'b0;
			filter_q   <= FILT_NONE;
			count_q    <= 16'd0;
			row_q      <= 16'd0;
			valid_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept && !err_stop_q;
			if (accept && !err_stop_q) begin
				if (awaiting_q) begin
					if (filtered_byte > 8'(FILT_PAETH)) begin
						err_stop_q <= 1'b1;
					end else begin
						filter_q   <= filtered_byte[2:0];
						awaiting_q <= 1'b0;
						count_q    <= 16'd0;
					end
				end else if (row_end) begin
					awaiting_q <= 1'b1;
					count_q    <= 16'd0;
					row_q      <= image_end ? 16'd0 : row_q + 16'd1;
				end else begin
					count_q <= count_q + 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.kind      <= awaiting_q ?
				((filtered_byte > 8'(FILT_PAETH)) ? ITEM_ERR : ITEM_TYPE) : ITEM_DATA;
			item_s1.filter    <= filter_q;
			item_s1.row0      <= (row_q == 16'd0);
			item_s1.row_end   <= row_end;
			item_s1.image_end <= image_end;
			item_s1.lag_sel   <= 3'(bpp - 5'd1);
			item_s1.eb        <= eb;
			item_s1.nsamp     <= nsamp;
			item_s1.count     <= count_q;
			item_s1.data      <= filtered_byte;
		end
	end

	assign rd_en   = accept && !err_stop_q && !awaiting_q;
	assign rd_addr = count_q;

endmodule

// ===== rtl/core/psu_recon.sv =====
// ----------------------------------------------------------------------------
// psu_recon
// Rebuilds each row byte from its left, upper and upper-left neighbors and
// keeps the prior row and the pixel histories.
// ----------------------------------------------------------------------------
module psu_recon #(
	parameter int MAX_ROW_BYTES   = 32768,
	parameter int MAX_PIXEL_BYTES = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  psu_pkg::front_item_t item_s1,
	input  logic                 valid_s1,
	input  logic                 rd_en,
	input  logic [15:0]          rd_addr,
	output logic                 wr_valid,
	output psu_pkg::entry_t      wr_entry
);
	import psu_pkg::*;

	localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
	localparam int HW = 8 * MAX_PIXEL_BYTES;
	localparam int LW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

	logic [7:0]    prior_mem [MAX_ROW_BYTES];
	logic [7:0]    rdata_q;
	logic [HW-1:0] left_q;
	logic [HW-1:0] upleft_q;

	logic [LW-1:0]     sel;
	logic [7:0]        a;
	logic [7:0]        b;
	logic [7:0]        c;
	logic [8:0]        avg_sum;
	logic signed [9:0] pa;
	logic signed [9:0] pb;
	logic signed [9:0] pc;
	logic [7:0]        pred;
	logic [7:0]        r;
	logic              is_data;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= prior_mem[AW'(rd_addr)];
		end
	end

	always_ff @(posedge clk) begin
		if (is_data) begin
			prior_mem[AW'(item_s1.count)] <= r;
		end
	end

	assign is_data = valid_s1 && (item_s1.kind == ITEM_DATA);

	always_comb begin
		sel     = LW'(item_s1.lag_sel);
		a       = left_q[8*sel +: 8];
		c       = upleft_q[8*sel +: 8];
		b       = item_s1.row0 ? 8'd0 : rdata_q;
		avg_sum = 9'(a) + 9'(b);
		pa      = 10'(b) - 10'(c);
		pb      = 10'(a) - 10'(c);
		pc      = 10'(a) + 10'(b) - 10'(c) - 10'(c);
		if (pa < 0) pa = -pa;
		if (pb < 0) pb = -pb;
		if (pc < 0) pc = -pc;
		case (item_s1.filter)
			FILT_SUB:   pred = a;
			FILT_UP:    pred = b;
			FILT_AVG:   pred = avg_sum[8:1];
			FILT_PAETH: begin
				if (pa <= pb && pa <= pc) begin
					pred = a;
				end else if (pb <= pc) begin
					pred = b;
				end else begin
					pred = c;
				end
			end
			default:    pred = 8'd0;
		endcase
		r = item_s1.data + pred;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			upleft_q <= '0;
		end else if (valid_s1) begin
			if (item_s1.kind == ITEM_TYPE) begin
				left_q   <= '0;
				upleft_q <= '0;
			end else if (item_s1.kind == ITEM_DATA) begin
				left_q   <= (left_q << 8) | HW'(r);
				upleft_q <= (upleft_q << 8) | HW'(b);
			end
		end
	end

	always_comb begin
		wr_valid = valid_s1 && ((item_s1.kind == ITEM_ERR) ||
			(item_s1.kind == ITEM_DATA && item_s1.nsamp != 4'd0));
		if (item_s1.kind == ITEM_ERR) begin
			wr_entry.value     = 8'd0;
			wr_entry.status    = 1'b1;
			wr_entry.eb        = 4'd8;
			wr_entry.nsamp     = 4'd1;
			wr_entry.row_end   = 1'b0;
			wr_entry.image_end = 1'b0;
		end else begin
			wr_entry.value     = r;
			wr_entry.status    = 1'b0;
			wr_entry.eb        = item_s1.eb;
			wr_entry.nsamp     = item_s1.nsamp;
			wr_entry.row_end   = item_s1.row_end;
			wr_entry.image_end = item_s1.image_end;
		end
	end

endmodule

// ===== rtl/core/psu_fifo.sv =====
// ----------------------------------------------------------------------------
// psu_fifo
// Short queue of reconstructed bytes between reconstruction and unpacking.
// ----------------------------------------------------------------------------
module psu_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_valid,
	input  psu_pkg::entry_t                 wr_entry,
	input  logic                            rd_pop,
	output psu_pkg::entry_t                 rd_entry,
	output logic                            rd_empty,
	output logic [psu_pkg::FIFO_CNT_W-1:0]  level
);
	import psu_pkg::*;

	entry_t                slot_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  do_pop;

	assign rd_empty = (count_q == '0);
	assign rd_entry = slot_q[rd_ptr_q];
	assign level    = count_q;
	assign do_pop   = rd_pop && !rd_empty;

	always_ff @(posedge clk) begin
		if (wr_valid) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_valid, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/psu_unpack.sv =====
// ----------------------------------------------------------------------------
// psu_unpack
// Splits each queued byte into right-aligned samples and marks row and image
// ends.
// ----------------------------------------------------------------------------
module psu_unpack (
	input  logic            clk,
	input  logic            arst_n,
	input  psu_pkg::entry_t head,
	input  logic            head_empty,
	output logic            head_pop,
	input  logic            pop,
	output logic            empty,
	output logic [7:0]      sample,
	output logic            status,
	output logic            last_in_row,
	output logic            last_in_image
);
	import psu_pkg::*;

	logic [2:0] k_q;
	logic [6:0] shamt_full;
	logic [7:0] aligned;
	logic       last_k;
	logic       take;

	assign shamt_full = 7'(head.eb) * 7'(k_q);
	assign aligned    = head.value << shamt_full[2:0];
	assign sample     = aligned >> (4'd8 - head.eb);
	assign last_k     = (4'(k_q) + 4'd1) >= head.nsamp;
	assign status     = head.status;
	assign last_in_row   = head.row_end && last_k;
	assign last_in_image = head.image_end && last_k;
	assign empty      = head_empty;
	assign take       = pop && !head_empty;
	assign head_pop   = take && last_k;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= 3'd0;
		end else if (take) begin
			k_q <= last_k ? 3'd0 : k_q + 3'd1;
		end
	end

endmodule

// ===== rtl/core/png_scanline_unfilter.sv =====
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG scanline filter reconstruction with sub-byte sample unpacking.
// ----------------------------------------------------------------------------
// Input queue side: present filtered_byte with push; the byte is taken on a
// clock edge where push is high and full is low. Each row is a filter-type
// byte followed by the row bytes. Result queue side: while empty is low the
// oldest result sits on sample/status/last_in_row/last_in_image; pop takes it.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 width,
// 1 height, 2 bits per pixel) at once; write only between items.
// Throughput: one byte per cycle in while full is low; each row byte leaves as
// 1 to 8 results, one per cycle while pop is high, so sub-byte depths give up
// to 8/bits results per byte. The Average and Paeth path is combinational on
// the left-neighbor loop. A taken byte is registered as the stage-1 item,
// then reconstructed and written into the result queue.
// Reset clears position, histories and queue, and sets width 1, height 1 and
// 8 bits per pixel; the first row after reset sees zeros above it.
// A stalled receiver fills the four-entry queue and then raises full.
// An unknown filter type gives one result with status 1; input is then
// taken and dropped until reset.
// ----------------------------------------------------------------------------
module png_scanline_unfilter #(
	parameter int MAX_ROW_BYTES   = 32768,
	parameter int MAX_PIXEL_BYTES = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [psu_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [psu_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             push,
	output logic                             full,
	input  logic [7:0]                       filtered_byte,
	output logic                             empty,
	input  logic                             pop,
	output logic [7:0]                       sample,
	output logic                             status,
	output logic                             last_in_row,
	output logic                             last_in_image
);
	import psu_pkg::*;

	front_item_t           item_s1;
	logic                  valid_s1;
	logic                  rd_en;
	logic [15:0]           rd_addr;
	logic                  wr_valid;
	entry_t                wr_entry;
	entry_t                head;
	logic                  head_empty;
	logic                  head_pop;
	logic [FIFO_CNT_W-1:0] level;

	assign full = (4'(level) + 4'(valid_s1)) >= 4'(FIFO_DEPTH);

	psu_front #(
		.MAX_ROW_BYTES   (MAX_ROW_BYTES),
		.MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.push          (push),
		.full          (full),
		.filtered_byte (filtered_byte),
		.item_s1       (item_s1),
		.valid_s1      (valid_s1),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr)
	);

	psu_recon #(
		.MAX_ROW_BYTES   (MAX_ROW_BYTES),
		.MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
	) u_recon (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_s1  (item_s1),
		.valid_s1 (valid_s1),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.wr_valid (wr_valid),
		.wr_entry (wr_entry)
	);

	psu_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (wr_valid),
		.wr_entry (wr_entry),
		.rd_pop   (head_pop),
		.rd_entry (head),
		.rd_empty (head_empty),
		.level    (level)
	);

	psu_unpack u_unpack (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_empty    (head_empty),
		.head_pop      (head_pop),
		.pop           (pop),
		.empty         (empty),
		.sample        (sample),
		.status        (status),
		.last_in_row   (last_in_row),
		.last_in_image (last_in_image)
	);

endmodule

// ===== tb/png_scanline_unfilter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// png_scanline_unfilter_test
// Self-checking bench for the PNG scanline unfilter. A driver pushes filtered
// stream bytes from a pending queue and a monitor pops results under random
// gaps. Every accepted byte runs through a cycle-free model of the five
// filters and the sub-byte unpacker, and each popped result is checked field
// by field against the oldest predicted one. Images cover the reset setup,
// all filters, packed and wide depths, odd and clamped register values,
// a width cut mid-row and the unknown-type stop.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_test;
	import psu_pkg::*;

	localparam int ROW_STORE   = 32768;
	localparam int PIX_MAX     = 8;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int DRAIN_WAIT  = 8;
	localparam int RANDOM_BYTES = 310;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	localparam logic [25*8-1:0] FIRST_IMAGE = {
		{5'd0, FILT_NONE},  8'hFF, 8'h00, 8'h80, 8'h7F,
		{5'd0, FILT_SUB},   8'h01, 8'hFF, 8'h10, 8'hF0,
		{5'd0, FILT_UP},    8'hFF, 8'hFF, 8'h00, 8'h01,
		{5'd0, FILT_AVG},   8'h80, 8'h81, 8'hFF, 8'h00,
		{5'd0, FILT_PAETH}, 8'h7F, 8'h80, 8'hFF, 8'h01
	};

	typedef struct packed {
		logic [7:0] sample;
		logic       status;
		logic       row_last;
		logic       image_last;
	} result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   push = 1'b0;
	logic                   full;
	logic [7:0]             filtered_byte = 8'h00;
	logic                   empty;
	logic                   pop = 1'b0;
	logic [7:0]             sample;
	logic                   status;
	logic                   last_in_row;
	logic                   last_in_image;

	png_scanline_unfilter u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.push          (push),
		.full          (full),
		.filtered_byte (filtered_byte),
		.empty         (empty),
		.pop           (pop),
		.sample        (sample),
		.status        (status),
		.last_in_row   (last_in_row),
		.last_in_image (last_in_image)
	);

	always #4 clk = ~clk;

	// model state
	logic [7:0]  prev_row [ROW_STORE];
	logic [63:0] left_bytes = '0;
	logic [63:0] upleft_bytes = '0;
	int unsigned row_idx = 0;
	int unsigned byte_idx = 0;
	logic [2:0]  cur_filter = FILT_NONE;
	bit          at_row_start = 1'b1;
	bit          halted = 1'b0;
	int unsigned reg_width = 1;
	int unsigned reg_height = 1;
	int unsigned reg_bits = 8;

	logic [7:0] bytes_to_send [$];
	result_t    samples_due [$];

	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit held = 1'b0;
	int bytes_taken = 0;
	int results_seen = 0;
	int mismatches = 0;
	int settings_used = 0;
	int cycles = 0;

	function automatic int unsigned depth_bits();
		if (reg_bits <= 1) return 1;
		if (reg_bits == 2) return 2;
		if (reg_bits <= 4) return 4;
		return 8;
	endfunction

	function automatic int unsigned pixel_bytes();
		int unsigned n;
		n = (reg_bits + 7) / 8;
		if (n < 1) n = 1;
		if (n > PIX_MAX) n = PIX_MAX;
		return n;
	endfunction

	function automatic int unsigned row_pixels();
		if (reg_width < 1) return 1;
		if (reg_width > 4096) return 4096;
		return reg_width;
	endfunction

	function automatic int unsigned row_len();
		int unsigned n;
		if (depth_bits() < 8) n = (row_pixels() * depth_bits() + 7) / 8;
		else n = row_pixels() * pixel_bytes();
		if (n > ROW_STORE) n = ROW_STORE;
		if (n < 1) n = 1;
		return n;
	endfunction

	function automatic int paeth_pick(input int a, input int b, input int c);
		int p, pa, pb, pc;
		p = a + b - c;
		pa = (p > a) ? p - a : a - p;
		pb = (p > b) ? p - b : b - p;
		pc = (p > c) ? p - c : c - p;
		if (pa <= pb && pa <= pc) return a;
		if (pb <= pc) return b;
		return c;
	endfunction

	task automatic unfilter_byte(input logic [7:0] x);
		result_t     outs [8];
		int          n, a, b, c, r, k, sh, mask, per, first;
		int unsigned eb, bpp, lag, len, hgt;
		logic [7:0]  r8;
		bit          row_end, img_end;
		n = 0;
		if (halted) return;
		if (at_row_start) begin
			if (x > FILT_PAETH) begin
				halted = 1'b1;
				samples_due.push_back('{8'h00, 1'b1, 1'b0, 1'b0});
			end else begin
				cur_filter = x[2:0];
				at_row_start = 1'b0;
				byte_idx = 0;
				left_bytes = '0;
				upleft_bytes = '0;
			end
			return;
		end
		eb = depth_bits();
		bpp = (eb < 8) ? 1 : pixel_bytes();
		lag = 8 * (bpp - 1);
		len = row_len();
		hgt = (reg_height < 1) ? 1 : reg_height;
		a = int'((left_bytes >> lag) & 64'hFF);
		c = int'((upleft_bytes >> lag) & 64'hFF);
		b = (row_idx > 0 && byte_idx < ROW_STORE) ? int'(prev_row[byte_idx]) : 0;
		case (cur_filter)
			FILT_SUB:   r = int'(x) + a;
			FILT_UP:    r = int'(x) + b;
			FILT_AVG:   r = int'(x) + ((a + b) >> 1);
			FILT_PAETH: r = int'(x) + paeth_pick(a, b, c);
			default:    r = int'(x);
		endcase
		r8 = r[7:0];
		if (byte_idx < ROW_STORE) prev_row[byte_idx] = r8;
		left_bytes = {left_bytes[55:0], r8};
		upleft_bytes = {upleft_bytes[55:0], 8'(b)};
		row_end = (byte_idx + 1 >= len);
		img_end = row_end && (row_idx + 1 >= hgt);
		if (eb >= 8) begin
			outs[0] = '{r8, 1'b0, 1'b0, 1'b0};
			n = 1;
		end else begin
			per = 8 / eb;
			first = byte_idx * per;
			mask = (1 << eb) - 1;
			for (k = 0; k < per && first + k < int'(row_pixels()); k++) begin
				sh = 8 - int'(eb) * (k + 1);
				outs[n] = '0;
				outs[n].sample = 8'((int'(r8) >> sh) & mask);
				n++;
			end
		end
		if (n > 0 && row_end) begin
			outs[n-1].row_last = 1'b1;
			outs[n-1].image_last = img_end;
		end
		for (k = 0; k < n; k++) samples_due.push_back(outs[k]);
		if (row_end) begin
			at_row_start = 1'b1;
			byte_idx = 0;
			row_idx = img_end ? 0 : ((row_idx + 1) & 16'hFFFF);
		end else begin
			byte_idx = (byte_idx + 1) & 16'hFFFF;
		end
	endtask

	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 8'h00;
		if (r < 20) return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40) $display("MISMATCH: %s", msg);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH:  reg_width = data[12:0];
			REG_IMAGE_HEIGHT: reg_height = data;
			REG_PIXEL_BITS:   reg_bits = data[6:0];
			default: ;
		endcase
	endtask

	task automatic queue_row(input logic [2:0] ftype, input int nbytes);
		@(negedge clk);
		bytes_to_send.push_back({5'd0, ftype});
		repeat (nbytes) bytes_to_send.push_back(pick_byte());
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (bytes_to_send.size() != 0 || samples_due.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin : driver
		logic       nxt_push;
		logic [7:0] nxt_byte;
		if (!arst_n) begin
			push <= 1'b0;
			filtered_byte <= 8'h00;
		end else begin
			nxt_push = push;
			nxt_byte = filtered_byte;
			if (push && !full) begin
				unfilter_byte(filtered_byte);
				void'(bytes_to_send.pop_front());
				bytes_taken++;
				nxt_push = 1'b0;
			end
			if (!nxt_push) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (bytes_to_send.size() > 0) begin
					nxt_push = 1'b1;
					nxt_byte = bytes_to_send[0];
					gap_left = ($urandom_range(0, 99) < 30) ? pick_gap() : 0;
				end
			end
			push <= nxt_push;
			filtered_byte <= nxt_byte;
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		result_t want;
		logic    nxt_pop;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (samples_due.size() == 0) begin
					report_mismatch($sformatf("result %0d (sample %0h) with none expected",
						results_seen, sample));
				end else begin
					want = samples_due.pop_front();
					if (sample !== want.sample)
						report_mismatch($sformatf("result %0d sample %0h, expected %0h",
							results_seen, sample, want.sample));
					if (status !== want.status)
						report_mismatch($sformatf("result %0d status %0b, expected %0b",
							results_seen, status, want.status));
					if (last_in_row !== want.row_last)
						report_mismatch($sformatf("result %0d last_in_row %0b, expected %0b",
							results_seen, last_in_row, want.row_last));
					if (last_in_image !== want.image_last)
						report_mismatch($sformatf("result %0d last_in_image %0b, expected %0b",
							results_seen, last_in_image, want.image_last));
				end
				results_seen++;
				if (results_seen == 3 && !held) begin
					hold_left = 250;
					held = 1'b1;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				nxt_pop = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				nxt_pop = 1'b0;
			end else begin
				nxt_pop = 1'b1;
				stall_left = ($urandom_range(0, 99) < 25) ? pick_gap() : 0;
			end
			pop <= nxt_pop;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", samples_due.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned plain_bits [9] = '{1, 2, 4, 8, 16, 24, 32, 48, 64};
		int unsigned odd_bits [10] = '{0, 3, 5, 6, 7, 12, 40, 65, 100, 127};
		int          i, rows, hgt, bv, wv, random_sent;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset setup: one pixel, one row, 8 bits
		queue_row(FILT_NONE, 1);
		wait_idle();

		write_reg(REG_IMAGE_WIDTH, 16'd2);
		write_reg(REG_IMAGE_HEIGHT, 16'd5);
		write_reg(REG_PIXEL_BITS, 16'd16);
		write_reg(REG_UNUSED, 16'($urandom));
		settings_used++;
		@(negedge clk);
		for (i = 24; i >= 0; i--) bytes_to_send.push_back(FIRST_IMAGE[i*8 +: 8]);
		wait_idle();

		// cut the width in the middle of a row
		write_reg(REG_IMAGE_WIDTH, 16'd4);
		write_reg(REG_IMAGE_HEIGHT, 16'd2);
		write_reg(REG_PIXEL_BITS, 16'd8);
		settings_used++;
		queue_row(FILT_NONE, 4);
		queue_row(FILT_AVG, 2);
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, 16'd2);
		@(negedge clk);
		bytes_to_send.push_back(pick_byte());
		wait_idle();

		// zero width, zero height, 1-bit samples
		write_reg(REG_IMAGE_WIDTH, 16'h0000);
		write_reg(REG_IMAGE_HEIGHT, 16'h0000);
		write_reg(REG_PIXEL_BITS, 16'd1);
		settings_used++;
		queue_row(3'($urandom_range(FILT_NONE, FILT_PAETH)), row_len());
		wait_idle();

		random_sent = 0;
		while (random_sent < RANDOM_BYTES) begin
			if ($urandom_range(0, 99) < 70) begin
				wait_idle();
				if ($urandom_range(0, 99) < 75) bv = plain_bits[$urandom_range(0, 8)];
				else bv = odd_bits[$urandom_range(0, 9)];
				i = $urandom_range(0, 99);
				if (bv > 8) wv = $urandom_range(1, 5);
				else if (i < 80) wv = $urandom_range(1, 8);
				else if (i < 90) wv = 0;
				else wv = $urandom_range(9, 20);
				i = $urandom_range(0, 99);
				if (i < 80) hgt = $urandom_range(1, 3);
				else if (i < 90) hgt = 0;
				else hgt = 65535;
				write_reg(REG_PIXEL_BITS, {9'($urandom), 7'(bv)});
				write_reg(REG_IMAGE_WIDTH, {3'($urandom), 13'(wv)});
				write_reg(REG_IMAGE_HEIGHT, 16'(hgt));
				settings_used++;
			end
			hgt = (reg_height < 1) ? 1 : reg_height;
			rows = (hgt > 3) ? 3 : hgt;
			repeat (rows) begin
				queue_row(3'($urandom_range(FILT_NONE, FILT_PAETH)), row_len());
				random_sent += 1 + row_len();
			end
			if (hgt > 3) begin
				// end a tall image early by dropping the height
				wait_idle();
				write_reg(REG_IMAGE_HEIGHT, 16'd1);
				queue_row(3'($urandom_range(FILT_NONE, FILT_PAETH)), row_len());
				random_sent += 1 + row_len();
			end
		end
		wait_idle();

		// unknown filter type, then bytes that must be dropped
		@(negedge clk);
		bytes_to_send.push_back(8'($urandom_range(5, 255)));
		repeat (8) bytes_to_send.push_back(pick_byte());
		wait_idle();
		repeat (20) @(posedge clk);

		$display("Pushed %0d bytes and checked %0d results over %0d register settings,",
			bytes_taken, results_seen, settings_used);
		$display("with all five filters, packed and wide depths, clamped values and the error stop.");
		if (mismatches == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule

// ===== png_scanline_unfilter.f =====
rtl/core/psu_pkg.sv
rtl/core/psu_front.sv
rtl/core/psu_recon.sv
rtl/core/psu_fifo.sv
rtl/core/psu_unpack.sv
rtl/core/png_scanline_unfilter.sv
tb/png_scanline_unfilter_test.sv
